[design/range_image_to_point_cloud_unit_assert.svh]
// Assertion macros shared by the range image to point cloud design.
`ifndef RANGE_IMAGE_TO_POINT_CLOUD_UNIT_ASSERT_SVH
`define RANGE_IMAGE_TO_POINT_CLOUD_UNIT_ASSERT_SVH

// A condition that must hold at every clock edge outside reset.
`define RLPC_CHECK(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);

// A condition that implies another one at the next clock edge.
`define RLPC_IMPLY_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[design/rlpc_pkg.sv]
// Shared constants, register indexes and the sine table generator.
package rlpc_pkg;

    localparam int RANGE_W   = 24;
    localparam int COORD_W   = 25;
    localparam int NUMBER_W  = 18;
    localparam int COUNT_W   = 19;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 32;
    localparam int COLS_REG_W = 12;
    localparam int ROWS_REG_W = 8;
    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 96;

    localparam int DEF_MAX_COLUMNS     = 2048;
    localparam int DEF_MAX_ROWS        = 128;
    localparam int DEF_RANGE_BITS      = 24;
    localparam int DEF_TRIG_TABLE_BITS = 10;
    localparam int DEF_TRIG_FRAC_BITS  = 16;

    localparam longint COORD_MAX = 64'sd16777215;
    localparam longint COORD_MIN = -64'sd16777216;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_RANGE_LOWER     = 3'd0,
        REG_RANGE_UPPER     = 3'd1,
        REG_AZIMUTH_START   = 3'd2,
        REG_AZIMUTH_STEP    = 3'd3,
        REG_ELEVATION_START = 3'd4,
        REG_ELEVATION_STEP  = 3'd5,
        REG_COLUMNS_IN_USE  = 3'd6,
        REG_ROWS_IN_USE     = 3'd7
    } t_reg_index;

    // Quarter-wave sine entry from a Taylor series in Q2.30, rounded to fb bits.
    function automatic logic [31:0] quarter_sine(input int unsigned idx, input int tb,
                                                 input int fb);
        longint unsigned theta;
        longint unsigned theta2;
        longint unsigned sum;
        longint unsigned term;
        longint unsigned res;
        longint unsigned part;
        int k;
        theta  = (longint'(idx) * 64'd1686629713) >> tb;
        theta2 = (theta * theta) >> 30;
        sum    = theta;
        term   = theta;
        for (k = 1; k <= 8; k++) begin
            part = (term * theta2) >> 30;
            // Series term k is divided by (2k)(2k+1).
            case (k)
                1:       term = part / 64'd6;
                2:       term = part / 64'd20;
                3:       term = part / 64'd42;
                4:       term = part / 64'd72;
                5:       term = part / 64'd110;
                6:       term = part / 64'd156;
                7:       term = part / 64'd210;
                default: term = part / 64'd272;
            endcase
            if (k[0]) begin
                sum = (sum >= term) ? sum - term : 64'd0;
            end else begin
                sum = sum + term;
            end
        end
        res = (sum + (64'd1 << (29 - fb))) >> (30 - fb);
        if (res > (64'd1 << fb)) begin
            res = 64'd1 << fb;
        end
        return res[31:0];
    endfunction

endpackage

[design/rlpc_sine_rom.sv]
// Quarter-wave sine table held in a synchronous read-only memory.
module rlpc_sine_rom #(
    parameter int TRIG_TABLE_BITS = rlpc_pkg::DEF_TRIG_TABLE_BITS,
    parameter int TRIG_FRAC_BITS  = rlpc_pkg::DEF_TRIG_FRAC_BITS
) (
    input  logic                      i_clk,
    input  logic [TRIG_TABLE_BITS:0]  i_addr,
    output logic [TRIG_FRAC_BITS:0]   o_data
);
    import rlpc_pkg::*;

    localparam int DEPTH = (1 << TRIG_TABLE_BITS) + 1;

    typedef logic [TRIG_FRAC_BITS:0] t_table [DEPTH];

    function automatic t_table build_table();
        t_table tab;
        logic [31:0] entry;
        for (int i = 0; i < DEPTH; i++) begin
            entry  = quarter_sine(i, TRIG_TABLE_BITS, TRIG_FRAC_BITS);
            tab[i] = entry[TRIG_FRAC_BITS:0];
        end
        return tab;
    endfunction

    localparam t_table SINE_MEM = build_table();

    logic [TRIG_FRAC_BITS:0] r_data;

    always_ff @(posedge i_clk) begin
        r_data <= SINE_MEM[i_addr];
    end

    assign o_data = r_data;
endmodule

[design/rlpc_scale_mul.sv]
// Shared sign-magnitude multiplier that scales a value by a trig factor.
module rlpc_scale_mul #(
    parameter int VALUE_W = rlpc_pkg::DEF_RANGE_BITS + 2,
    parameter int TRIG_W  = rlpc_pkg::DEF_TRIG_FRAC_BITS + 2,
    parameter int FRAC_W  = rlpc_pkg::DEF_TRIG_FRAC_BITS
) (
    input  logic                       i_clk,
    input  logic                       i_start,
    input  logic signed [VALUE_W-1:0]  i_value,
    input  logic signed [TRIG_W-1:0]   i_trig,
    output logic signed [VALUE_W-1:0]  o_result
);
    localparam int PROD_W = VALUE_W + TRIG_W;

    logic                      neg;
    logic [VALUE_W-1:0]        mag_v;
    logic [TRIG_W-1:0]         mag_t;
    logic [PROD_W:0]           prod;
    logic [PROD_W:0]           rounded;
    logic [VALUE_W-1:0]        mag_p;
    logic signed [VALUE_W-1:0] r_result;

    always_comb begin
        neg     = i_value[VALUE_W-1] ^ i_trig[TRIG_W-1];
        mag_v   = i_value[VALUE_W-1] ? VALUE_W'(-i_value) : VALUE_W'(i_value);
        mag_t   = i_trig[TRIG_W-1] ? TRIG_W'(-i_trig) : TRIG_W'(i_trig);
        prod    = (PROD_W + 1)'(mag_v) * (PROD_W + 1)'(mag_t);
        rounded = prod + ((PROD_W + 1)'(1) << (FRAC_W - 1));
        mag_p   = VALUE_W'(rounded >> FRAC_W);
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_result <= neg ? -$signed(mag_p) : $signed(mag_p);
        end
    end

    assign o_result = r_result;
endmodule

[design/range_image_to_point_cloud_unit.sv]
// From an accepted pixel beat the sequencer steps through the table reads (elevation cosine
// and sine at column 0 only, then azimuth cosine and sine), the four products and S_OUT,
// which waits for a free output. A pixel is accepted only while idle; the row sine and cosine
// are read only at column 0, the reads share one table port and the products one multiplier.
// Reset (synchronous, active low) restores the register defaults and restarts the frame;
// any configuration write also restarts it. The sine table is constant and needs no clearing.
module range_image_to_point_cloud_unit #(
    parameter int MAX_COLUMNS     = rlpc_pkg::DEF_MAX_COLUMNS,
    parameter int MAX_ROWS        = rlpc_pkg::DEF_MAX_ROWS,
    parameter int RANGE_BITS      = rlpc_pkg::DEF_RANGE_BITS,
    parameter int TRIG_TABLE_BITS = rlpc_pkg::DEF_TRIG_TABLE_BITS,
    parameter int TRIG_FRAC_BITS  = rlpc_pkg::DEF_TRIG_FRAC_BITS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Configuration write port.
    input  logic                              i_cfg_we,
    input  logic [rlpc_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [rlpc_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    // Pixel beats in.
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [rlpc_pkg::IN_DATA_W-1:0]    s_axis_tdata,  // [23:0] range_value
    input  logic                              s_axis_tuser,  // [0] range_not_finite
    // Point beats out.
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [rlpc_pkg::OUT_DATA_W-1:0]   m_axis_tdata,  // [24:0] point_x, [49:25] point_y,
                                                             // [74:50] point_z,
                                                             // [92:75] point_number, zero pad
    output logic                              m_axis_tuser,  // [0] point_valid
    output logic                              m_axis_tlast   // frame_end
);
    import rlpc_pkg::*;

    localparam int COL_W  = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
    localparam int ROW_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int VAL_W  = RANGE_BITS + 2;
    localparam int TRIG_W = TRIG_FRAC_BITS + 2;
    localparam int IDX_W  = TRIG_TABLE_BITS + 1;

    // Each pixel runs through the table reads, then the four products.
    typedef enum logic [3:0] {
        S_IDLE, S_EL_COS, S_EL_SIN, S_AZ_COS, S_AZ_SIN,
        S_MUL_RC, S_MUL_X, S_MUL_Y, S_MUL_Z, S_OUT
    } t_state;

    // Destination of the table word, which arrives in the cycle after its address.
    typedef enum logic [2:0] {
        D_NONE, D_ROW_COS, D_ROW_SIN, D_AZ_COS, D_AZ_SIN
    } t_dest;

    typedef struct packed {
        logic [IDX_W-1:0] idx;
        logic             neg;
    } t_trig_sel;

    // Binary angle to table address: top two bits pick the quadrant, the rest
    // is rounded half up to the table resolution and mirrored in odd quadrants.
    function automatic t_trig_sel trig_sel(input logic [31:0] angle);
        t_trig_sel   sel;
        logic [30:0] sum;
        logic [IDX_W-1:0] idx;
        sum = {1'b0, angle[29:0]} + (31'd1 << (29 - TRIG_TABLE_BITS));
        idx = sum[30:30-TRIG_TABLE_BITS];
        if (angle[30]) begin
            idx = (IDX_W'(1) << TRIG_TABLE_BITS) - idx;
        end
        sel.idx = idx;
        sel.neg = angle[31];
        return sel;
    endfunction

    function automatic logic [COORD_W-1:0] saturate(input logic signed [VAL_W-1:0] v);
        longint wide;
        wide = longint'(v);
        if (wide > COORD_MAX) begin
            wide = COORD_MAX;
        end else if (wide < COORD_MIN) begin
            wide = COORD_MIN;
        end
        return wide[COORD_W-1:0];
    endfunction

    // Configuration registers.
    logic [RANGE_W-1:0]    r_range_lower;
    logic [RANGE_W-1:0]    r_range_upper;
    logic [31:0]           r_az_start;
    logic [31:0]           r_az_step;
    logic [31:0]           r_el_start;
    logic [31:0]           r_el_step;
    logic [COLS_REG_W-1:0] r_cols_reg;
    logic [ROWS_REG_W-1:0] r_rows_reg;

    // Frame state.
    t_state                   r_state;
    logic [COL_W-1:0]         r_col;
    logic [ROW_W-1:0]         r_row;
    logic [31:0]              r_az;
    logic [31:0]              r_el;
    logic signed [TRIG_W-1:0] r_row_cos;
    logic signed [TRIG_W-1:0] r_row_sin;
    logic [COUNT_W-1:0]       r_count;

    // Pixel work registers.
    logic [RANGE_BITS-1:0]    r_range;
    logic                     r_px_valid;
    t_dest                    r_rd_dest;
    logic                     r_rd_neg;
    logic signed [TRIG_W-1:0] r_az_cos;
    logic signed [TRIG_W-1:0] r_az_sin;
    logic signed [VAL_W-1:0]  r_rc;
    logic [COORD_W-1:0]       r_x;
    logic [COORD_W-1:0]       r_y;

    // Output register.
    logic                     r_m_valid;
    logic [OUT_DATA_W-1:0]    r_m_data;
    logic                     r_m_user;
    logic                     r_m_last;

    // Combinational signals.
    logic [31:0]              in_range_ext;
    logic [RANGE_BITS-1:0]    in_range;
    logic                     in_valid;
    logic [COL_W:0]           eff_cols;
    logic [ROW_W:0]           eff_rows;
    logic                     row_done;
    logic                     frame_done;
    logic [COL_W:0]           n_col;
    logic [ROW_W:0]           n_row;
    t_trig_sel                sel;
    t_dest                    rd_dest;
    logic [IDX_W-1:0]         rom_addr;
    logic [TRIG_FRAC_BITS:0]  rom_data;
    logic signed [TRIG_W-1:0] rom_signed;
    logic                     mul_start;
    logic signed [VAL_W-1:0]  mul_value;
    logic signed [TRIG_W-1:0] mul_trig;
    logic signed [VAL_W-1:0]  mul_result;
    logic                     out_free;
    logic                     accept;

    assign accept        = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (r_state == S_IDLE);
    assign out_free      = !r_m_valid || m_axis_tready;

    // Range taken modulo 2^RANGE_BITS; the window compare is exclusive at both ends.
    always_comb begin
        in_range_ext = 32'(s_axis_tdata);
        in_range     = in_range_ext[RANGE_BITS-1:0];
        in_valid     = !s_axis_tuser
                       && (32'(in_range) > 32'(r_range_lower))
                       && (32'(in_range) < 32'(r_range_upper));
    end

    // A geometry of zero acts as one; anything above the maximum is clamped.
    always_comb begin
        if (r_cols_reg == '0) begin
            eff_cols = (COL_W + 1)'(1);
        end else if (32'(r_cols_reg) > 32'(MAX_COLUMNS)) begin
            eff_cols = (COL_W + 1)'(MAX_COLUMNS);
        end else begin
            eff_cols = (COL_W + 1)'(r_cols_reg);
        end
        if (r_rows_reg == '0) begin
            eff_rows = (ROW_W + 1)'(1);
        end else if (32'(r_rows_reg) > 32'(MAX_ROWS)) begin
            eff_rows = (ROW_W + 1)'(MAX_ROWS);
        end else begin
            eff_rows = (ROW_W + 1)'(r_rows_reg);
        end
        n_col      = (COL_W + 1)'(r_col) + (COL_W + 1)'(1);
        n_row      = (ROW_W + 1)'(r_row) + (ROW_W + 1)'(1);
        row_done   = (n_col >= eff_cols);
        frame_done = row_done && (n_row >= eff_rows);
    end

    // Table address: cosine reads are the sine a quarter turn ahead.
    always_comb begin
        case (r_state)
            S_EL_COS: begin
                sel     = trig_sel(r_el + 32'h4000_0000);
                rd_dest = D_ROW_COS;
            end
            S_EL_SIN: begin
                sel     = trig_sel(r_el);
                rd_dest = D_ROW_SIN;
            end
            S_AZ_COS: begin
                sel     = trig_sel(r_az + 32'h4000_0000);
                rd_dest = D_AZ_COS;
            end
            S_AZ_SIN: begin
                sel     = trig_sel(r_az);
                rd_dest = D_AZ_SIN;
            end
            default: begin
                sel     = '0;
                rd_dest = D_NONE;
            end
        endcase
        rom_addr   = sel.idx;
        rom_signed = r_rd_neg ? -$signed({1'b0, rom_data}) : $signed({1'b0, rom_data});
    end

    rlpc_sine_rom #(
        .TRIG_TABLE_BITS (TRIG_TABLE_BITS),
        .TRIG_FRAC_BITS  (TRIG_FRAC_BITS)
    ) u_sine_rom (
        .i_clk  (i_clk),
        .i_addr (rom_addr),
        .o_data (rom_data)
    );

    // Multiplier operands: r*cosV, then (r*cosV)*cosH, (r*cosV)*sinH, r*sinV.
    always_comb begin
        mul_start = 1'b1;
        case (r_state)
            S_MUL_RC: begin
                mul_value = VAL_W'(signed'({1'b0, r_range}));
                mul_trig  = r_row_cos;
            end
            S_MUL_X: begin
                mul_value = mul_result;
                mul_trig  = r_az_cos;
            end
            S_MUL_Y: begin
                mul_value = r_rc;
                mul_trig  = r_az_sin;
            end
            S_MUL_Z: begin
                mul_value = VAL_W'(signed'({1'b0, r_range}));
                mul_trig  = r_row_sin;
            end
            default: begin
                mul_start = 1'b0;
                mul_value = '0;
                mul_trig  = '0;
            end
        endcase
    end

    rlpc_scale_mul #(
        .VALUE_W (VAL_W),
        .TRIG_W  (TRIG_W),
        .FRAC_W  (TRIG_FRAC_BITS)
    ) u_scale_mul (
        .i_clk    (i_clk),
        .i_start  (mul_start),
        .i_value  (mul_value),
        .i_trig   (mul_trig),
        .o_result (mul_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_range_lower <= '0;
            r_range_upper <= '1;
            r_az_start    <= '0;
            r_az_step     <= '0;
            r_el_start    <= '0;
            r_el_step     <= '0;
            r_cols_reg    <= COLS_REG_W'(2048);
            r_rows_reg    <= ROWS_REG_W'(128);
            r_col         <= '0;
            r_row         <= '0;
            r_az          <= '0;
            r_el          <= '0;
            r_row_cos     <= '0;
            r_row_sin     <= '0;
            r_count       <= '0;
            r_rd_dest     <= D_NONE;
            r_m_valid     <= 1'b0;
        end else begin
            r_rd_dest <= rd_dest;
            r_rd_neg  <= sel.neg;
            case (r_rd_dest)
                D_ROW_COS: r_row_cos <= rom_signed;
                D_ROW_SIN: r_row_sin <= rom_signed;
                D_AZ_COS:  r_az_cos  <= rom_signed;
                D_AZ_SIN:  r_az_sin  <= rom_signed;
                default: ;
            endcase

            // The output register is reloaded from the finishing state instead.
            if (m_axis_tready && r_state != S_OUT) begin
                r_m_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_range    <= in_range;
                        r_px_valid <= in_valid;
                        r_state    <= (r_col == '0) ? S_EL_COS : S_AZ_COS;
                    end
                end
                S_EL_COS: r_state <= S_EL_SIN;
                S_EL_SIN: r_state <= S_AZ_COS;
                S_AZ_COS: r_state <= S_AZ_SIN;
                S_AZ_SIN: r_state <= S_MUL_RC;
                S_MUL_RC: r_state <= S_MUL_X;
                S_MUL_X: begin
                    r_rc    <= mul_result;
                    r_state <= S_MUL_Y;
                end
                S_MUL_Y: begin
                    r_x     <= saturate(mul_result);
                    r_state <= S_MUL_Z;
                end
                S_MUL_Z: begin
                    r_y     <= saturate(mul_result);
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (out_free) begin
                        r_m_valid <= 1'b1;
                        r_m_user  <= r_px_valid;
                        r_m_last  <= frame_done;
                        if (r_px_valid) begin
                            r_m_data <= {(OUT_DATA_W - 3 * COORD_W - NUMBER_W)'(0),
                                         r_count[NUMBER_W-1:0], saturate(mul_result),
                                         r_y, r_x};
                            if (!frame_done) begin
                                r_count <= r_count + COUNT_W'(1);
                            end
                        end else begin
                            r_m_data <= '0;
                        end
                        // Step the position and angles; the last pixel restarts the frame.
                        if (row_done) begin
                            r_col <= '0;
                            r_az  <= r_az_start;
                            if (frame_done) begin
                                r_row     <= '0;
                                r_el      <= r_el_start;
                                r_row_cos <= '0;
                                r_row_sin <= '0;
                                r_count   <= '0;
                            end else begin
                                r_row <= n_row[ROW_W-1:0];
                                r_el  <= r_el + r_el_step;
                            end
                        end else begin
                            r_col <= n_col[COL_W-1:0];
                            r_az  <= r_az + r_az_step;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase

            // User writes a register only while idle (unenforced); a write restarts the frame.
            if (i_cfg_we) begin
                case (t_reg_index'(i_cfg_index))
                    REG_RANGE_LOWER:     r_range_lower <= i_cfg_data[RANGE_W-1:0];
                    REG_RANGE_UPPER:     r_range_upper <= i_cfg_data[RANGE_W-1:0];
                    REG_AZIMUTH_START:   r_az_start    <= i_cfg_data;
                    REG_AZIMUTH_STEP:    r_az_step     <= i_cfg_data;
                    REG_ELEVATION_START: r_el_start    <= i_cfg_data;
                    REG_ELEVATION_STEP:  r_el_step     <= i_cfg_data;
                    REG_COLUMNS_IN_USE:  r_cols_reg    <= i_cfg_data[COLS_REG_W-1:0];
                    REG_ROWS_IN_USE:     r_rows_reg    <= i_cfg_data[ROWS_REG_W-1:0];
                    default: ;
                endcase
                r_col     <= '0;
                r_row     <= '0;
                r_row_cos <= '0;
                r_row_sin <= '0;
                r_count   <= '0;
                r_az      <= (t_reg_index'(i_cfg_index) == REG_AZIMUTH_START)
                             ? i_cfg_data : r_az_start;
                r_el      <= (t_reg_index'(i_cfg_index) == REG_ELEVATION_START)
                             ? i_cfg_data : r_el_start;
            end
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;
    assign m_axis_tuser  = r_m_user;
    assign m_axis_tlast  = r_m_last;

    `include "range_image_to_point_cloud_unit_assert.svh"

    `RLPC_IMPLY_NEXT(a_accept_leaves_idle, accept, r_state != S_IDLE, "pixel accepted but sequencer stayed idle")
    `RLPC_CHECK(a_invalid_point_zero, !(r_m_valid && !r_m_user) || r_m_data == '0, "invalid point carries nonzero data")
    `RLPC_CHECK(a_column_in_range, (COL_W + 1)'(r_col) < eff_cols, "column counter beyond image width")
    `RLPC_IMPLY_NEXT(a_out_load_returns_idle, r_state == S_OUT && out_free, r_m_valid && r_state == S_IDLE, "finished pixel did not reach the output register")
endmodule
